>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the checker files of this block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define BMM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define BMM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`endif

>>> rtl/bmm_pkg.sv
// ---------------------------------------------------------------------------
// bmm_pkg
// Shared constants and types of the bipartite matching engine.
// ---------------------------------------------------------------------------
`default_nettype none

package bmm_pkg;

  localparam int MAX_LEFT  = 32;
  localparam int MAX_RIGHT = 32;
  localparam int ROW_W     = 32;
  localparam int LEFT_W    = $clog2(MAX_LEFT);
  localparam int RIGHT_W   = $clog2(ROW_W);
  localparam int CNT_W     = 6;

  typedef struct packed {
    logic start;
    logic take;
  } search_cmd_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } search_res_t;

endpackage

`default_nettype wire

>>> rtl/bmm_row_store.sv
// ---------------------------------------------------------------------------
// bmm_row_store
// Adjacency rows of the loaded graph, one per left vertex, with a row count.
// ---------------------------------------------------------------------------
`default_nettype none

module bmm_row_store (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [bmm_pkg::ROW_W-1:0]   wr_data,
  input  logic                        clear,
  input  logic [bmm_pkg::LEFT_W-1:0]  rd_addr,
  output logic [bmm_pkg::ROW_W-1:0]   rd_data,
  output logic [bmm_pkg::CNT_W-1:0]   rows
);
  import bmm_pkg::*;

  logic [ROW_W-1:0] mem [MAX_LEFT];
  logic             has_room;

  // Rows beyond the store depth are dropped.
  assign has_room = (rows < CNT_W'(MAX_LEFT));
  assign rd_data  = mem[rd_addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= '0;
    end else if (clear) begin
      rows <= '0;
    end else if (wr_en && has_room) begin
      rows <= rows + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && has_room) begin
      mem[rows[LEFT_W-1:0]] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bmm_search.sv
// ---------------------------------------------------------------------------
// bmm_search
// Augmenting-path sequencer: one right vertex is tested per cycle of scanning,
// with an explicit stack of suspended left vertices and an owner table.
// ---------------------------------------------------------------------------
`default_nettype none

module bmm_search (
  input  logic                        clk,
  input  logic                        rst,
  input  bmm_pkg::search_cmd_t        cmd,
  input  logic [bmm_pkg::CNT_W-1:0]   rows,
  input  logic [bmm_pkg::CNT_W-1:0]   nr,
  output logic [bmm_pkg::LEFT_W-1:0]  rd_addr,
  input  logic [bmm_pkg::ROW_W-1:0]   row,
  output logic                        busy,
  output bmm_pkg::search_res_t        res
);
  import bmm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_UNWIND,
    S_DONE
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   left_idx;
  logic [LEFT_W-1:0]  cur_left;
  logic [CNT_W-1:0]   r;
  logic [CNT_W-1:0]   sp;
  logic [CNT_W-1:0]   matched;
  logic [ROW_W-1:0]   visited;
  logic [MAX_RIGHT-1:0] owner_valid;
  logic [LEFT_W-1:0]  owner     [MAX_RIGHT];
  logic [LEFT_W-1:0]  stk_left  [MAX_LEFT];
  logic [RIGHT_W-1:0] stk_chosen [MAX_LEFT];

  logic [RIGHT_W-1:0] r_idx;
  logic [CNT_W-1:0]   sp_m1;
  logic [LEFT_W-1:0]  top_idx;
  logic               in_range;
  logic               cand;
  logic               owned;

  assign r_idx    = r[RIGHT_W-1:0];
  assign sp_m1    = sp - CNT_W'(1);
  assign top_idx  = sp_m1[LEFT_W-1:0];
  assign in_range = (r < nr);
  assign cand     = in_range && row[r_idx] && !visited[r_idx];
  assign owned    = owner_valid[r_idx];
  assign rd_addr  = cur_left;
  assign busy     = (state != S_IDLE);

  assign res.valid = (state == S_DONE) && cmd.take;
  assign res.count = matched;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      owner_valid <= '0;
      matched     <= '0;
      left_idx    <= '0;
      sp          <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.start) begin
            matched  <= '0;
            left_idx <= '0;
            state    <= S_START;
          end
        end
        S_START: begin
          if (left_idx == rows) begin
            state <= S_DONE;
          end else begin
            cur_left <= left_idx[LEFT_W-1:0];
            r        <= '0;
            sp       <= '0;
            visited  <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!in_range) begin
            if (sp == '0) begin
              // No augmenting path from this left vertex.
              left_idx <= left_idx + CNT_W'(1);
              state    <= S_START;
            end else begin
              cur_left <= stk_left[top_idx];
              r        <= CNT_W'(stk_chosen[top_idx]) + CNT_W'(1);
              sp       <= sp_m1;
            end
          end else if (cand) begin
            visited[r_idx] <= 1'b1;
            if (!owned) begin
              owner_valid[r_idx] <= 1'b1;
              state              <= S_UNWIND;
            end else begin
              sp       <= sp + CNT_W'(1);
              cur_left <= owner[r_idx];
              r        <= '0;
            end
          end else begin
            r <= r + CNT_W'(1);
          end
        end
        S_UNWIND: begin
          if (sp == '0) begin
            matched  <= matched + CNT_W'(1);
            left_idx <= left_idx + CNT_W'(1);
            state    <= S_START;
          end else begin
            owner_valid[stk_chosen[top_idx]] <= 1'b1;
            sp                               <= sp_m1;
          end
        end
        S_DONE: begin
          if (cmd.take) begin
            owner_valid <= '0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Owner table and stack: one write port each.
  always_ff @(posedge clk) begin
    if (state == S_SCAN && cand && !owned) begin
      owner[r_idx] <= cur_left;
    end else if (state == S_UNWIND && sp != '0) begin
      owner[stk_chosen[top_idx]] <= stk_left[top_idx];
    end
    if (state == S_SCAN && cand && owned) begin
      stk_left[sp[LEFT_W-1:0]]   <= cur_left;
      stk_chosen[sp[LEFT_W-1:0]] <= r_idx;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bipartite_max_matching.sv
// ---------------------------------------------------------------------------
// bipartite_max_matching
// Maximum bipartite matching by augmenting paths over a loaded bit graph.
// ---------------------------------------------------------------------------
//
//   channel   signals                               beat
//   cfg       cfg_valid, cfg_ready, num_right       one register write
//   in        in_valid, in_ready, adjacency_row,    one left vertex row
//             last_row
//   out       out_valid, out_ready, match_count     one matching size
//
// An ordinary row beat leaves in_ready high, so rows follow back to back.
// The beat with last_row set starts the search; in_ready stays low until the
// result is handed to the output register. The search tests one right
// vertex per cycle in the shared scan step; each row takes a start step,
// then scan, push and pop steps, then unwind steps if a path is found,
// and a done step waits for the output register. The output register lets
// the next graph load while a result still waits. Reset is synchronous and
// needs no clearing pass; cfg_ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module bipartite_max_matching (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bmm_pkg::CNT_W-1:0]  num_right,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bmm_pkg::ROW_W-1:0]  adjacency_row,
  input  logic                       last_row,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bmm_pkg::CNT_W-1:0]  match_count
);
  import bmm_pkg::*;

  logic [CNT_W-1:0]  nr_reg;
  logic [CNT_W-1:0]  nr_eff;
  logic              start_pend;
  logic              in_acc;
  logic              busy;
  logic [CNT_W-1:0]  rows;
  logic [LEFT_W-1:0] rd_addr;
  logic [ROW_W-1:0]  rd_data;
  search_cmd_t       cmd;
  search_res_t       res;

  assign cfg_ready = 1'b1;

  // The right count in use never exceeds the row width.
  assign nr_eff = (nr_reg > CNT_W'(MAX_RIGHT)) ? CNT_W'(MAX_RIGHT) : nr_reg;

  // Rows load while the search is idle; the cycle after the last row is
  // blocked until the sequencer has picked up the start.
  assign in_ready = !busy && !start_pend;
  assign in_acc   = in_valid && in_ready;

  assign cmd.start = start_pend;
  assign cmd.take  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      nr_reg     <= CNT_W'(MAX_RIGHT);
      start_pend <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        nr_reg <= num_right;
      end
      start_pend <= in_acc && last_row;
      if (res.valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      match_count <= res.count;
    end
  end

  bmm_row_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_acc),
    .wr_data (adjacency_row),
    .clear   (res.valid),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rows    (rows)
  );

  bmm_search u_search (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rows    (rows),
    .nr      (nr_eff),
    .rd_addr (rd_addr),
    .row     (rd_data),
    .busy    (busy),
    .res     (res)
  );

endmodule

`default_nettype wire

>>> rtl/bmm_checker.sv
// ---------------------------------------------------------------------------
// bmm_checker
// Port-level checks of the matching engine, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bmm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       last_row,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [bmm_pkg::CNT_W-1:0]  match_count
);
  import bmm_pkg::*;

  `BMM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(match_count))
  `BMM_ASSERT_NOW(a_count_range, clk, rst, out_valid, match_count <= CNT_W'(MAX_LEFT))
  `BMM_ASSERT_NEXT(a_rows_stream, clk, rst, in_valid && in_ready && !last_row, in_ready)
  `BMM_ASSERT_NEXT(a_last_stalls, clk, rst, in_valid && in_ready && last_row, !in_ready)

endmodule

bind bipartite_max_matching bmm_checker u_bmm_checker (.*);

`default_nettype wire
